FILE: hw/rtl/phm_pkg.sv
// shared types, widths, stage map and constants for the peak hold level meter
`default_nettype none

package phm_pkg;

    // channel and field widths
    localparam int CHANNELS = 4;
    localparam int LEVEL_W  = 16;
    localparam int GAIN_W   = 16;
    localparam int HOLD_W   = 8;
    localparam int SEG_W    = 5;
    localparam int PEAK_W   = 11;

    // bar scale
    localparam int SEGMENTS = 24;
    localparam int SEGC_W   = $clog2(SEGMENTS + 1);
    localparam int SEGM1_W  = $clog2(SEGMENTS);

    // log2 datapath: Q1.16 mantissa, 16 fraction bits, one squaring per stage
    localparam int FRAC_W = 16;
    localparam int EXP_W  = 4;
    localparam int MANT_W = LEVEL_W + 1;
    localparam int L2_W   = 1 + EXP_W + FRAC_W;
    localparam logic signed [L2_W-1:0] L2_OFFSET = L2_W'(14 << FRAC_W);

    // tenths of dB per octave in Q16, product in Q32
    localparam int TPL_W    = 24;
    localparam logic signed [TPL_W-1:0] TENTHS_PER_LOG2 = TPL_W'(3945660);
    localparam int TENTHS_W = 44;

    // dB window of the scale, 60 dB = 600 tenths
    localparam int DB_SPAN = 600;
    localparam logic signed [TENTHS_W-1:0] SPAN_Q32 = TENTHS_W'(64'd600 << 32);
    localparam logic signed [TENTHS_W-1:0] HALF_Q32 = TENTHS_W'(64'd1 << 31);
    localparam int P_W     = 42;
    localparam int PROD_W  = P_W + SEGM1_W;
    localparam int NUM_W   = PROD_W - 32 + 1;

    // floor(n / 600) as (n * RECIP) >> RECIP_SH, exact for n below 125000
    localparam int RECIP_SH = 26;
    localparam int RECIP_W  = 17;
    localparam logic [RECIP_W-1:0] RECIP =
        RECIP_W'(((64'd1 << RECIP_SH) + DB_SPAN - 1) / DB_SPAN);

    localparam logic signed [PEAK_W-1:0] PEAK_SILENT = -11'sd1000;

    // pipeline stage map, stage 0 is the channel state itself
    localparam int ST_ENTRY    = 0;
    localparam int ST_NORM     = 1;
    localparam int ST_SQ_LAST  = ST_NORM + FRAC_W;
    localparam int ST_MUL      = ST_SQ_LAST + 1;
    localparam int ST_SUM      = ST_MUL + 1;
    localparam int ST_OUT      = ST_SUM + 1;
    localparam int NUM_STAGES  = ST_OUT + 1;

    typedef logic [NUM_STAGES-1:0] stage_vec_t;

    // stream widths
    localparam int S_TDATA_W   = CHANNELS * LEVEL_W;
    localparam int OUT_BITS    = CHANNELS * (2 * SEG_W + PEAK_W);
    localparam int M_TDATA_W   = ((OUT_BITS + 7) / 8) * 8;
    localparam int MARK_BASE   = CHANNELS * SEG_W;
    localparam int PEAK_BASE   = 2 * CHANNELS * SEG_W;

    // configuration registers
    localparam int CFG_ADDR_W = 2;
    localparam int CFG_DATA_W = 16;

    typedef enum logic [CFG_ADDR_W-1:0] {
        CFG_DISPLAY_DECAY = 2'd0,
        CFG_HOLD_TIME     = 2'd1,
        CFG_HOLD_DECAY    = 2'd2
    } cfg_idx_t;

    localparam logic [GAIN_W-1:0] RST_DISPLAY_DECAY = 16'd52429;
    localparam logic [HOLD_W-1:0] RST_HOLD_TIME     = 8'd24;
    localparam logic [GAIN_W-1:0] RST_HOLD_DECAY    = 16'd60293;

    typedef struct packed {
        logic [GAIN_W-1:0] display_decay;
        logic [HOLD_W-1:0] hold_time;
        logic [GAIN_W-1:0] hold_decay;
    } cfg_t;

endpackage

`default_nettype wire

FILE: hw/rtl/phm_log2_pipe.sv
// pipelined log2 of a Q2.14 level: normalize, then one squaring step per stage
`default_nettype none

module phm_log2_pipe (
    input  wire logic                                 clk,
    input  wire phm_pkg::stage_vec_t                  en,
    input  wire logic [phm_pkg::LEVEL_W-1:0]          level,
    output logic signed [phm_pkg::L2_W-1:0]           log2_q16,
    output logic                                      silent
);

    logic [phm_pkg::EXP_W-1:0]  exp_c;
    logic [phm_pkg::EXP_W:0]    shamt_c;
    logic [phm_pkg::MANT_W-1:0] mant_c;

    logic [phm_pkg::MANT_W-1:0] mant_reg   [phm_pkg::FRAC_W];
    logic [phm_pkg::FRAC_W-1:0] frac_reg   [phm_pkg::FRAC_W+1];
    logic [phm_pkg::EXP_W-1:0]  exp_reg    [phm_pkg::FRAC_W+1];
    logic                       silent_reg [phm_pkg::FRAC_W+1];

    // leading one position
    always_comb
    begin
        exp_c = '0;
        for (int b = 1; b < phm_pkg::LEVEL_W; b++)
        begin
            if (level[b])
            begin
                exp_c = phm_pkg::EXP_W'(b);
            end
        end
    end

    // shift the leading one up to the Q1.16 unit position
    assign shamt_c = (phm_pkg::EXP_W+1)'(phm_pkg::LEVEL_W) - {1'b0, exp_c};
    assign mant_c  = phm_pkg::MANT_W'(level) << shamt_c;

    // normalize stage
    always_ff @(posedge clk)
    begin
        if (en[phm_pkg::ST_NORM])
        begin
            mant_reg[0]   <= mant_c;
            frac_reg[0]   <= '0;
            exp_reg[0]    <= exp_c;
            silent_reg[0] <= (level == '0);
        end
    end

    // squaring stages, each yields one fraction bit, msb first
    for (genvar k = 1; k <= phm_pkg::FRAC_W; k++)
    begin : g_sq
        logic [2*phm_pkg::MANT_W-1:0] sq_c;
        logic [phm_pkg::MANT_W:0]     sq_hi_c;

        assign sq_c    = mant_reg[k-1] * mant_reg[k-1];
        assign sq_hi_c = sq_c[2*phm_pkg::MANT_W-1:phm_pkg::FRAC_W];

        always_ff @(posedge clk)
        begin
            if (en[phm_pkg::ST_NORM+k])
            begin
                frac_reg[k]   <= {frac_reg[k-1][phm_pkg::FRAC_W-2:0],
                                  sq_hi_c[phm_pkg::MANT_W]};
                exp_reg[k]    <= exp_reg[k-1];
                silent_reg[k] <= silent_reg[k-1];
            end
        end

        // the last stage only needs its fraction bit
        if (k < phm_pkg::FRAC_W)
        begin : g_mant
            always_ff @(posedge clk)
            begin
                if (en[phm_pkg::ST_NORM+k])
                begin
                    if (sq_hi_c[phm_pkg::MANT_W])
                    begin
                        mant_reg[k] <= sq_hi_c[phm_pkg::MANT_W:1];
                    end
                    else
                    begin
                        mant_reg[k] <= sq_hi_c[phm_pkg::MANT_W-1:0];
                    end
                end
            end
        end
    end

    // log2 of the Q2.14 value in Q16
    assign log2_q16 = $signed({1'b0, exp_reg[phm_pkg::FRAC_W], frac_reg[phm_pkg::FRAC_W]})
                      - phm_pkg::L2_OFFSET;
    assign silent   = silent_reg[phm_pkg::FRAC_W];

endmodule

`default_nettype wire

FILE: hw/rtl/phm_scale.sv
// dB scaling: log2 to tenths of dB, bar segment count and rounded peak
`default_nettype none

module phm_scale (
    input  wire logic                                 clk,
    input  wire phm_pkg::stage_vec_t                  en,
    input  wire logic signed [phm_pkg::L2_W-1:0]      log2_q16,
    input  wire logic                                 silent,
    output logic [phm_pkg::SEG_W-1:0]                 seg,
    output logic signed [phm_pkg::PEAK_W-1:0]         peak
);

    logic signed [phm_pkg::L2_W+phm_pkg::TPL_W-1:0] tenths_c;
    logic signed [phm_pkg::TENTHS_W-1:0]            tenths_reg;
    logic                                           silent_reg;

    logic signed [phm_pkg::TENTHS_W-1:0] pos_c;
    logic signed [phm_pkg::TENTHS_W-1:0] rnd_c;
    logic [phm_pkg::PROD_W-1:0]          scaled_c;
    logic [phm_pkg::NUM_W-1:0]           num_c;
    logic                                floor_c;
    logic                                full_c;

    logic [phm_pkg::NUM_W-1:0]           num_reg;
    logic                                floor_reg;
    logic                                full_reg;
    logic signed [phm_pkg::PEAK_W-1:0]   peak_reg;

    logic [phm_pkg::NUM_W+phm_pkg::RECIP_W-1:0] qprod_c;
    logic [phm_pkg::SEGC_W-1:0]                 quot_c;
    logic [phm_pkg::SEGC_W-1:0]                 seg_c;

    logic [phm_pkg::SEG_W-1:0]          seg_reg;
    logic signed [phm_pkg::PEAK_W-1:0]  peak_out_reg;

    // tenths of dB in Q32
    assign tenths_c = log2_q16 * phm_pkg::TENTHS_PER_LOG2;

    always_ff @(posedge clk)
    begin
        if (en[phm_pkg::ST_MUL])
        begin
            tenths_reg <= $signed(tenths_c[phm_pkg::TENTHS_W-1:0]);
            silent_reg <= silent;
        end
    end

    // position above the -60 dB floor, rounded segment numerator, rounded peak
    assign pos_c    = tenths_reg + phm_pkg::SPAN_Q32;
    assign floor_c  = pos_c[phm_pkg::TENTHS_W-1] || (pos_c == '0);
    assign full_c   = (pos_c >= phm_pkg::SPAN_Q32);
    assign scaled_c = phm_pkg::PROD_W'(pos_c[phm_pkg::P_W-1:0])
                      * phm_pkg::PROD_W'(phm_pkg::SEGMENTS - 1);
    assign num_c    = phm_pkg::NUM_W'(scaled_c[phm_pkg::PROD_W-1:32])
                      + phm_pkg::NUM_W'(phm_pkg::DB_SPAN / 2);
    assign rnd_c    = tenths_reg + phm_pkg::HALF_Q32;

    always_ff @(posedge clk)
    begin
        if (en[phm_pkg::ST_SUM])
        begin
            num_reg   <= num_c;
            floor_reg <= silent_reg || floor_c;
            full_reg  <= full_c;
            if (silent_reg)
            begin
                peak_reg <= phm_pkg::PEAK_SILENT;
            end
            else
            begin
                peak_reg <= $signed(rnd_c[phm_pkg::PEAK_W+31:32]);
            end
        end
    end

    // divide the numerator by the 600 tenths span
    assign qprod_c = num_reg * phm_pkg::RECIP;
    assign quot_c  = phm_pkg::SEGC_W'(qprod_c >> phm_pkg::RECIP_SH);

    always_comb
    begin
        if (floor_reg)
        begin
            seg_c = '0;
        end
        else if (full_reg)
        begin
            seg_c = phm_pkg::SEGC_W'(phm_pkg::SEGMENTS);
        end
        else
        begin
            seg_c = quot_c + phm_pkg::SEGC_W'(1);
        end
    end

    // output register of the lane
    always_ff @(posedge clk)
    begin
        if (en[phm_pkg::ST_OUT])
        begin
            seg_reg      <= phm_pkg::SEG_W'(seg_c);
            peak_out_reg <= peak_reg;
        end
    end

    assign seg  = seg_reg;
    assign peak = peak_out_reg;

endmodule

`default_nettype wire

FILE: hw/rtl/phm_lane.sv
// one meter channel: display and hold state, two log pipelines, two scalers
`default_nettype none

module phm_lane (
    input  wire logic                                 clk,
    input  wire logic                                 rst_n,
    input  wire logic                                 acc,
    input  wire phm_pkg::stage_vec_t                  en,
    input  wire phm_pkg::cfg_t                        cfg,
    input  wire logic [phm_pkg::LEVEL_W-1:0]          level,
    output logic [phm_pkg::SEG_W-1:0]                 bar,
    output logic [phm_pkg::SEG_W-1:0]                 mark,
    output logic signed [phm_pkg::PEAK_W-1:0]         peak
);

    logic [phm_pkg::LEVEL_W-1:0] shown_reg;
    logic [phm_pkg::LEVEL_W-1:0] shown_next;
    logic [phm_pkg::LEVEL_W-1:0] held_reg;
    logic [phm_pkg::LEVEL_W-1:0] held_next;
    logic [phm_pkg::HOLD_W-1:0]  hold_left_reg;
    logic [phm_pkg::HOLD_W-1:0]  hold_left_next;

    logic [phm_pkg::LEVEL_W+phm_pkg::GAIN_W-1:0] shown_prod_c;
    logic [phm_pkg::LEVEL_W+phm_pkg::GAIN_W-1:0] held_prod_c;

    logic signed [phm_pkg::L2_W-1:0] shown_l2;
    logic signed [phm_pkg::L2_W-1:0] held_l2;
    logic                            shown_silent;
    logic                            held_silent;

    // decayed levels, truncated
    assign shown_prod_c = shown_reg * cfg.display_decay;
    assign held_prod_c  = held_reg * cfg.hold_decay;

    // peak follow, hold countdown and decay
    always_comb
    begin
        shown_next     = shown_reg;
        held_next      = held_reg;
        hold_left_next = hold_left_reg;
        if (acc)
        begin
            if (level > shown_reg)
            begin
                shown_next = level;
            end
            else
            begin
                shown_next = shown_prod_c[phm_pkg::LEVEL_W+phm_pkg::GAIN_W-1:phm_pkg::GAIN_W];
            end

            if (level >= held_reg)
            begin
                held_next      = level;
                hold_left_next = cfg.hold_time;
            end
            else if (hold_left_reg != '0)
            begin
                hold_left_next = hold_left_reg - phm_pkg::HOLD_W'(1);
            end
            else
            begin
                held_next = held_prod_c[phm_pkg::LEVEL_W+phm_pkg::GAIN_W-1:phm_pkg::GAIN_W];
            end
        end
    end

    // channel state, also the entry stage of the pipeline
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            shown_reg     <= '0;
            held_reg      <= '0;
            hold_left_reg <= '0;
        end
        else
        begin
            shown_reg     <= shown_next;
            held_reg      <= held_next;
            hold_left_reg <= hold_left_next;
        end
    end

    // display level path
    phm_log2_pipe u_shown_log (
        .clk      (clk),
        .en       (en),
        .level    (shown_reg),
        .log2_q16 (shown_l2),
        .silent   (shown_silent)
    );

    phm_scale u_shown_scale (
        .clk      (clk),
        .en       (en),
        .log2_q16 (shown_l2),
        .silent   (shown_silent),
        .seg      (bar),
        .peak     ()
    );

    // hold level path
    phm_log2_pipe u_held_log (
        .clk      (clk),
        .en       (en),
        .level    (held_reg),
        .log2_q16 (held_l2),
        .silent   (held_silent)
    );

    phm_scale u_held_scale (
        .clk      (clk),
        .en       (en),
        .log2_q16 (held_l2),
        .silent   (held_silent),
        .seg      (mark),
        .peak     (peak)
    );

endmodule

`default_nettype wire

FILE: hw/rtl/peak_hold_level_meter.sv
// top level: config registers, stage flow control, four channel lanes, result packing
//
//  channel   | direction | handshake         | contents
//  ----------+-----------+-------------------+---------------------------------------
//  s_*       | in        | s_tvalid/s_tready | one meter tick, four Q2.14 levels
//  m_*       | out       | m_tvalid/m_tready | bars, hold marks, hold peaks per channel
//  cfg_*     | in        | cfg_wr_en         | decay gains and hold time, no read-back
//
//  one tick per cycle sustained while the output is not stalled; each input transfer
//  passes through channel state update, normalize, the 16 squaring stages of the log2
//  pipelines, then multiply, sum and output stages, 21 stages in all.
//  reset clears all levels and hold counters and loads the register defaults.
//  a stalled output holds its transfer; earlier stages keep advancing into
//  empty slots, so s_tready drops only once every stage holds a tick.
`default_nettype none

module peak_hold_level_meter (
    input  wire logic                                 clk,
    input  wire logic                                 rst_n,
    // level_in_left, level_in_right, level_out_left, level_out_right
    input  wire logic [phm_pkg::S_TDATA_W-1:0]        s_tdata,
    input  wire logic                                 s_tvalid,
    output logic                                      s_tready,
    // bar_in_left, bar_in_right, bar_out_left, bar_out_right,
    // mark_in_left, mark_in_right, mark_out_left, mark_out_right,
    // peak_in_left, peak_in_right, peak_out_left, peak_out_right, zero fill
    output logic [phm_pkg::M_TDATA_W-1:0]             m_tdata,
    output logic                                      m_tvalid,
    input  wire logic                                 m_tready,
    input  wire logic                                 cfg_wr_en,
    input  wire logic [phm_pkg::CFG_ADDR_W-1:0]       cfg_addr,
    input  wire logic [phm_pkg::CFG_DATA_W-1:0]       cfg_wdata
);

    phm_pkg::cfg_t       cfg_reg;
    phm_pkg::cfg_t       cfg_next;
    phm_pkg::stage_vec_t valid_reg;
    phm_pkg::stage_vec_t valid_next;
    phm_pkg::stage_vec_t rdy;
    logic                acc;

    logic [phm_pkg::SEG_W-1:0]         bar  [phm_pkg::CHANNELS];
    logic [phm_pkg::SEG_W-1:0]         mark [phm_pkg::CHANNELS];
    logic signed [phm_pkg::PEAK_W-1:0] peak [phm_pkg::CHANNELS];

    // register writes
    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_wr_en)
        begin
            case (cfg_addr)
                phm_pkg::CFG_DISPLAY_DECAY:
                begin
                    cfg_next.display_decay = cfg_wdata[phm_pkg::GAIN_W-1:0];
                end
                phm_pkg::CFG_HOLD_TIME:
                begin
                    cfg_next.hold_time = cfg_wdata[phm_pkg::HOLD_W-1:0];
                end
                phm_pkg::CFG_HOLD_DECAY:
                begin
                    cfg_next.hold_decay = cfg_wdata[phm_pkg::GAIN_W-1:0];
                end
                default:
                begin
                    cfg_next = cfg_reg;
                end
            endcase
        end
    end

    // a stage loads when it is empty or the next one loads
    assign rdy[phm_pkg::NUM_STAGES-1] = ~valid_reg[phm_pkg::NUM_STAGES-1] | m_tready;
    for (genvar i = 0; i < phm_pkg::NUM_STAGES - 1; i++)
    begin : g_rdy
        assign rdy[i] = ~valid_reg[i] | rdy[i+1];
    end

    assign s_tready = rdy[phm_pkg::ST_ENTRY];
    assign acc      = s_tvalid & rdy[phm_pkg::ST_ENTRY];
    assign m_tvalid = valid_reg[phm_pkg::ST_OUT];

    // stage valid flags
    always_comb
    begin
        valid_next = valid_reg;
        if (rdy[phm_pkg::ST_ENTRY])
        begin
            valid_next[phm_pkg::ST_ENTRY] = s_tvalid;
        end
        for (int i = 1; i < phm_pkg::NUM_STAGES; i++)
        begin
            if (rdy[i])
            begin
                valid_next[i] = valid_reg[i-1];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.display_decay <= phm_pkg::RST_DISPLAY_DECAY;
            cfg_reg.hold_time     <= phm_pkg::RST_HOLD_TIME;
            cfg_reg.hold_decay    <= phm_pkg::RST_HOLD_DECAY;
            valid_reg             <= '0;
        end
        else
        begin
            cfg_reg   <= cfg_next;
            valid_reg <= valid_next;
        end
    end

    // channel lanes
    for (genvar c = 0; c < phm_pkg::CHANNELS; c++)
    begin : g_lane
        phm_lane u_lane (
            .clk   (clk),
            .rst_n (rst_n),
            .acc   (acc),
            .en    (rdy),
            .cfg   (cfg_reg),
            .level (s_tdata[c*phm_pkg::LEVEL_W +: phm_pkg::LEVEL_W]),
            .bar   (bar[c]),
            .mark  (mark[c]),
            .peak  (peak[c])
        );
    end

    // merge lane results into one transfer
    always_comb
    begin
        m_tdata = '0;
        for (int c = 0; c < phm_pkg::CHANNELS; c++)
        begin
            m_tdata[c*phm_pkg::SEG_W +: phm_pkg::SEG_W] = bar[c];
            m_tdata[phm_pkg::MARK_BASE + c*phm_pkg::SEG_W +: phm_pkg::SEG_W] = mark[c];
            m_tdata[phm_pkg::PEAK_BASE + c*phm_pkg::PEAK_W +: phm_pkg::PEAK_W] = peak[c];
        end
    end

endmodule

`default_nettype wire

FILE: hw/rtl/phm_checker.sv
// port-level assertions for the peak hold level meter, bound to the top level
`default_nettype none

module phm_checker (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire logic                           s_tvalid,
    input  wire logic                           s_tready,
    input  wire logic [phm_pkg::M_TDATA_W-1:0]  m_tdata,
    input  wire logic                           m_tvalid,
    input  wire logic                           m_tready
);

    logic silent_ok;

    // a silent hold peak always comes with no hold mark
    always_comb
    begin
        silent_ok = 1'b1;
        for (int c = 0; c < phm_pkg::CHANNELS; c++)
        begin
            if ((m_tdata[phm_pkg::PEAK_BASE + c*phm_pkg::PEAK_W +: phm_pkg::PEAK_W]
                 == phm_pkg::PEAK_SILENT)
                && (m_tdata[phm_pkg::MARK_BASE + c*phm_pkg::SEG_W +: phm_pkg::SEG_W] != '0))
            begin
                silent_ok = 1'b0;
            end
        end
    end

    // input side never blocks while the output slot can move
    a_ready_when_free: assert property (@(posedge clk) disable iff (!rst_n)
        (!m_tvalid || m_tready) |-> s_tready)
        else $error("input stalled while output slot free");

    // stalled result holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata)))
        else $error("stalled result changed");

    // fill bits of the result stay zero
    a_fill_zero: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> (m_tdata[phm_pkg::M_TDATA_W-1:phm_pkg::OUT_BITS] == '0))
        else $error("fill bits set");

    a_silent_mark: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> silent_ok)
        else $error("hold mark shown for a silent hold level");

endmodule

bind peak_hold_level_meter phm_checker u_phm_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tdata  (m_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready)
);

`default_nettype wire
